[hw/rtl/assert_macros.svh]
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is applied.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[hw/rtl/upd_pkg.sv]
package upd_pkg;

  // Character codes
  localparam logic [7:0] CHAR_PCT   = 8'h25;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_HASH  = 8'h23;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;

  // Nibble corrections for letter digits
  localparam logic [7:0] HI_LETTER_ADJ = 8'h90;
  localparam logic [7:0] LO_LETTER_ADJ = 8'h09;

  // Results per transaction and output queue geometry
  localparam int unsigned MAX_EMIT   = 3;
  localparam int unsigned EMIT_CW    = $clog2(MAX_EMIT + 1);
  localparam int unsigned FIFO_DEPTH = 8;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CW    = FIFO_AW + 1;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_PCT   = 2'd1,
    PH_DIGIT = 2'd2
  } phase_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } upd_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } upd_out_t;

  function automatic logic is_hex(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
           (c >= 8'h61 && c <= 8'h66);
  endfunction

  // Two hex digits to a byte, 8-bit arithmetic as in the escape rules
  function automatic logic [7:0] hex_pair(input logic [7:0] hi, input logic [7:0] lo);
    logic [7:0] v_hi;
    logic [7:0] v;
    v_hi = {hi[3:0], 4'h0};
    if (hi >= CHAR_UPPER_A) v_hi = v_hi + HI_LETTER_ADJ;
    v = {v_hi[7:4], lo[3:0]};
    if (lo >= CHAR_UPPER_A) v = v + LO_LETTER_ADJ;
    return v;
  endfunction

endpackage

[hw/rtl/url_partial_percent_decoder.sv]
// Partial URL percent decoder. Accepts one URL byte per transaction on the
// input channel (in_last on the final byte) and emits the decoded string on
// the output channel, one byte per transaction, with out_last on the final
// byte. "%XY" with two hex digits becomes the encoded byte, except for the
// space, '#' and '%' codes, which stay escaped; malformed escapes pass through
// and the bytes after the '%' are scanned again. Each input byte is decoded in
// the cycle it is accepted and yields zero to three output bytes, which are
// registered in the output queue. Input is taken every cycle as long as an
// eight-entry output queue has room for three bytes; the output drains one
// byte per cycle while out_ready_i is high, so a stream averaging at most
// one output byte per input byte runs at one byte per cycle.
`include "assert_macros.svh"

module url_partial_percent_decoder
  import upd_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  upd_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output upd_out_t out_data_o
);

  phase_e     phase_q, phase_d;
  logic [7:0] held_q, held_d;

  logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [FIFO_CW-1:0] count_q, count_d;
  upd_out_t           fifo_q [FIFO_DEPTH];

  upd_out_t           emit [MAX_EMIT];
  logic [EMIT_CW-1:0] emit_cnt;
  logic [EMIT_CW-1:0] pre_cnt;
  logic               tail_en;
  logic               push, pop;
  logic               b_hex;
  logic [7:0]         pair;
  logic [7:0]         b;
  logic               last;

  assign b     = in_data_i.in_byte;
  assign last  = in_data_i.in_last;
  assign b_hex = is_hex(b);
  assign pair  = hex_pair(held_q, b);

  assign push = in_valid_i && in_ready_o;
  assign pop  = out_valid_o && out_ready_i;

  // Room for a full burst of results
  assign in_ready_o  = (count_q <= FIFO_CW'(FIFO_DEPTH - MAX_EMIT));
  assign out_valid_o = (count_q != '0);
  assign out_data_o  = fifo_q[rd_ptr_q];

  // Escape decode: results and next phase
  always_comb begin
    for (int i = 0; i < MAX_EMIT; i++) begin
      emit[i] = '{out_byte: b, out_last: 1'b0};
    end
    emit_cnt = '0;
    pre_cnt  = '0;
    tail_en  = 1'b0;
    phase_d  = phase_q;
    held_d   = held_q;

    case (phase_q)
      PH_PCT: begin
        if (b_hex) begin
          if (last) begin
            emit[0].out_byte = CHAR_PCT;
            emit[1].out_byte = b;
            emit_cnt = EMIT_CW'(2);
            phase_d  = PH_IDLE;
          end else begin
            held_d  = b;
            phase_d = PH_DIGIT;
          end
        end else begin
          emit[0].out_byte = CHAR_PCT;
          pre_cnt = EMIT_CW'(1);
          tail_en = 1'b1;
        end
      end
      PH_DIGIT: begin
        phase_d = PH_IDLE;
        if (b_hex) begin
          if (pair != CHAR_SPACE && pair != CHAR_HASH && pair != CHAR_PCT) begin
            emit[0].out_byte = pair;
            emit_cnt = EMIT_CW'(1);
          end else begin
            emit[0].out_byte = CHAR_PCT;
            emit[1].out_byte = held_q;
            emit[2].out_byte = b;
            emit_cnt = EMIT_CW'(3);
          end
        end else begin
          emit[0].out_byte = CHAR_PCT;
          emit[1].out_byte = held_q;
          pre_cnt = EMIT_CW'(2);
          tail_en = 1'b1;
        end
      end
      default: begin
        tail_en = 1'b1;
      end
    endcase

    // Byte handled as if it arrived while idle
    if (tail_en) begin
      if (b == CHAR_PCT && !last) begin
        emit_cnt = pre_cnt;
        phase_d  = PH_PCT;
      end else begin
        emit[pre_cnt].out_byte = b;
        emit_cnt = pre_cnt + EMIT_CW'(1);
        phase_d  = PH_IDLE;
      end
    end

    // End of string: flag the final result, drop anything held
    if (last) begin
      phase_d = PH_IDLE;
      if (emit_cnt != '0) begin
        emit[emit_cnt - EMIT_CW'(1)].out_last = 1'b1;
      end
    end
  end

  assign count_d = count_q + (push ? FIFO_CW'(emit_cnt) : '0) - FIFO_CW'(pop);

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      held_q   <= '0;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        phase_q  <= phase_d;
        held_q   <= held_d;
        wr_ptr_q <= wr_ptr_q + FIFO_AW'(emit_cnt);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
      end
      count_q <= count_d;
    end
  end

  // Output queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      for (int i = 0; i < MAX_EMIT; i++) begin
        if (EMIT_CW'(i) < emit_cnt) begin
          fifo_q[wr_ptr_q + FIFO_AW'(i)] <= emit[i];
        end
      end
    end
  end

  `ASSERT_CLK(a_count_bound, count_q <= FIFO_CW'(FIFO_DEPTH), "output queue overflow")
  `ASSERT_CLK(a_ptr_count, count_q[FIFO_AW-1:0] == FIFO_AW'(wr_ptr_q - rd_ptr_q), "queue pointers and count disagree")
  `ASSERT_CLK(a_last_idle, push && last |=> phase_q == PH_IDLE, "phase not idle after end of string")
  `ASSERT_CLK(a_last_emits, push && last |=> count_q != '0, "end of string produced no result")

endmodule

[sim/tb_url_partial_percent_decoder.sv]
module tb_url_partial_percent_decoder;
  import upd_pkg::*;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  upd_in_t  in_data = '0;
  logic     in_ready;
  logic     out_valid;
  logic     out_ready = 1'b0;
  upd_out_t out_data;

  // Traffic shaping knobs, percent of cycles
  int snd_gap_pct = 0;
  int rcv_stall_pct = 0;
  int hold_left = 0;
  int mismatch_cnt = 0;

  // Decoder shadow state and the bytes it still owes
  phase_e     dec_phase = PH_IDLE;
  logic [7:0] held_hi = '0;
  logic [7:0] step_bytes[$];
  upd_out_t   decoded_q[$];
  upd_out_t   want_out;

  always #10 clk = ~clk;

  url_partial_percent_decoder u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  function automatic logic hex_char(input logic [7:0] c);
    logic [7:0] lc;
    lc = c | 8'h20;
    return (c >= 8'h30 && c <= 8'h39) || (lc >= 8'h61 && lc <= 8'h66);
  endfunction

  // Valid digits only: letters of either case land on 10..15
  function automatic logic [3:0] hex_val(input logic [7:0] c);
    return (c <= 8'h39) ? c[3:0] : c[3:0] + 4'd9;
  endfunction

  // Byte handled as if nothing were held
  function automatic void idle_byte(input logic [7:0] b, input logic l);
    if (b == CHAR_PCT && !l) begin
      dec_phase = PH_PCT;
    end else begin
      step_bytes.push_back(b);
      dec_phase = PH_IDLE;
    end
  endfunction

  // Expected output bytes for one accepted input transaction
  function automatic void predict_decode(input logic [7:0] b, input logic l);
    logic [7:0] val;
    int         k;
    step_bytes.delete();
    case (dec_phase)
      PH_PCT: begin
        if (hex_char(b) && !l) begin
          held_hi = b;
          dec_phase = PH_DIGIT;
        end else if (hex_char(b)) begin
          step_bytes.push_back(CHAR_PCT);
          step_bytes.push_back(b);
        end else begin
          step_bytes.push_back(CHAR_PCT);
          idle_byte(b, l);
        end
      end
      PH_DIGIT: begin
        if (hex_char(b)) begin
          val = {hex_val(held_hi), hex_val(b)};
          // space, hash and percent stay escaped
          if (val == CHAR_SPACE || val == CHAR_HASH || val == CHAR_PCT) begin
            step_bytes.push_back(CHAR_PCT);
            step_bytes.push_back(held_hi);
            step_bytes.push_back(b);
          end else begin
            step_bytes.push_back(val);
          end
          dec_phase = PH_IDLE;
        end else begin
          step_bytes.push_back(CHAR_PCT);
          step_bytes.push_back(held_hi);
          idle_byte(b, l);
        end
      end
      default: idle_byte(b, l);
    endcase
    if (l) dec_phase = PH_IDLE;
    for (k = 0; k < step_bytes.size(); k++) begin
      decoded_q.push_back(upd_out_t'({step_bytes[k], l && (k == step_bytes.size() - 1)}));
    end
  endfunction

  function automatic logic [7:0] rand_hex();
    int v;
    v = $urandom_range(0, 15);
    if (v < 10) return 8'(8'h30 + v);
    return 8'(($urandom_range(0, 1) ? 8'h61 : 8'h41) + v - 10);
  endfunction

  // Offer one input transaction, with random idle cycles ahead of it
  task automatic send_char(input logic [7:0] b, input logic l);
    while ($urandom_range(0, 99) < snd_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= {b, l};
    do @(posedge clk); while (!in_ready);
    predict_decode(b, l);
  endtask

  // Whole string, end flag on its final byte
  task automatic send_str(input string s);
    int i;
    for (i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  // Stop offering input and wait until every expected byte has been seen
  task automatic wait_drain();
    in_valid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
  endtask

  // Output side: compare each transaction, then pick next cycle's ready
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (decoded_q.size() == 0) begin
          $display("%0t: unexpected output: byte %h last %b",
                   $time, out_data.out_byte, out_data.out_last);
          mismatch_cnt++;
        end else begin
          want_out = decoded_q.pop_front();
          if (out_data.out_byte !== want_out.out_byte) begin
            $display("%0t: out_byte mismatch: expected %h, got %h",
                     $time, want_out.out_byte, out_data.out_byte);
            mismatch_cnt++;
          end
          if (out_data.out_last !== want_out.out_last) begin
            $display("%0t: out_last mismatch: expected %b, got %b",
                     $time, want_out.out_last, out_data.out_last);
            mismatch_cnt++;
          end
        end
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= rcv_stall_pct);
      end
    end
  end

  // Field extremes, both digit cases, excepted codes, broken escapes,
  // end of string while an escape is held
  task automatic test_directed();
    snd_gap_pct = 0;
    rcv_stall_pct = 0;
    send_char(8'h00, 1'b0);
    send_char(8'hFF, 1'b1);
    send_str("%4a%fF");
    send_str("%20%23%25");
    send_str("%G%4Z%%41");
    send_str("%");
    send_str("%9");
    wait_drain();
  endtask

  // Random URL-like strings: mostly escapes and text, some noise
  task automatic test_random_traffic(input int gap_pct, input int stall_pct,
                                     input int n_items);
    logic [7:0] url[$];
    int         sent;
    int         len;
    int         kind;
    int         j;
    int         k;
    snd_gap_pct = gap_pct;
    rcv_stall_pct = stall_pct;
    sent = 0;
    while (sent < n_items) begin
      url.delete();
      len = $urandom_range(1, 6);
      for (j = 0; j < len; j++) begin
        kind = $urandom_range(0, 9);
        if (kind <= 2) begin
          url.push_back(8'($urandom_range(8'h21, 8'h7E)));
        end else if (kind <= 5) begin
          url.push_back(CHAR_PCT);
          url.push_back(rand_hex());
          url.push_back(rand_hex());
        end else if (kind == 6) begin
          url.push_back(CHAR_PCT);
          url.push_back(8'h32);
          case ($urandom_range(0, 2))
            0:       url.push_back(8'h30);
            1:       url.push_back(8'h33);
            default: url.push_back(8'h35);
          endcase
        end else if (kind == 7) begin
          url.push_back(CHAR_PCT);
          url.push_back(rand_hex());
          url.push_back(8'($urandom_range(0, 255)));
        end else if (kind == 8) begin
          url.push_back(CHAR_PCT);
          url.push_back(8'($urandom_range(0, 255)));
        end else begin
          url.push_back(8'($urandom_range(0, 255)));
        end
      end
      for (k = 0; k < url.size(); k++) send_char(url[k], k == url.size() - 1);
      sent += url.size();
    end
  endtask

  // Receiver holds off while the sender keeps going, so the queue fills
  task automatic test_backpressure();
    snd_gap_pct = 0;
    rcv_stall_pct = 0;
    hold_left = 150;
    repeat (10) send_str("%25x");
    wait_drain();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_traffic(0, 0, 25);
    test_random_traffic(66, 0, 25);
    test_random_traffic(0, 66, 25);
    test_random_traffic(20, 20, 25);
    test_backpressure();
    wait_drain();
    repeat (20) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(200000 * 20);
    $display("FAILURE");
    $finish;
  end

endmodule

[url_partial_percent_decoder.f]
+incdir+hw/rtl
hw/rtl/upd_pkg.sv
hw/rtl/url_partial_percent_decoder.sv
sim/tb_url_partial_percent_decoder.sv
